// ===== design/assert_macros.svh =====
// Assertion macros used by the chapter heading detector back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CHD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define CHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CHD_ASSERT(label, clk, rst_n, prop, msg)

`define CHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/chd_pkg.sv =====
// Types, code unit constants and classification functions of the heading detector.
`default_nettype none

package chd_pkg;

    localparam int UNIT_BITS       = 16;
    localparam int OUT_OFFSET_BITS = 32;

    localparam logic [UNIT_BITS-1:0] UNIT_NEWLINE   = 16'h000A;
    localparam logic [UNIT_BITS-1:0] UNIT_ZERO      = 16'h0000;
    localparam logic [UNIT_BITS-1:0] UNIT_MARKER    = 16'h7B2C;
    localparam logic [UNIT_BITS-1:0] UNIT_VOLUME    = 16'h5377;
    localparam logic [UNIT_BITS-1:0] UNIT_CHAPTER   = 16'h7AE0;
    localparam logic [UNIT_BITS-1:0] UNIT_PART      = 16'h90E8;
    localparam logic [UNIT_BITS-1:0] UNIT_SECTION   = 16'h8282;
    localparam logic [UNIT_BITS-1:0] UNIT_PRO_FIRST = 16'h6954;
    localparam logic [UNIT_BITS-1:0] UNIT_PRO_SECOND = 16'h5B50;
    localparam logic [UNIT_BITS-1:0] UNIT_PREF_FIRST = 16'h5E8F;
    localparam logic [UNIT_BITS-1:0] UNIT_SPACE     = 16'h0020;
    localparam logic [UNIT_BITS-1:0] UNIT_TAB       = 16'h0009;
    localparam logic [UNIT_BITS-1:0] UNIT_IDEO_SPACE = 16'h3000;
    localparam logic [UNIT_BITS-1:0] UNIT_NBSP      = 16'h00A0;
    localparam logic [UNIT_BITS-1:0] UNIT_WIDE_COLON = 16'hFF1A;
    localparam logic [UNIT_BITS-1:0] UNIT_COLON     = 16'h003A;

    typedef enum logic [1:0] {
        KIND_NUMBERED = 2'd0,
        KIND_PROLOGUE = 2'd1,
        KIND_PREFACE  = 2'd2
    } heading_kind_t;

    // Everything the line scanner needs to know about one code unit.
    typedef struct packed {
        logic newline;
        logic zero;
        logic separator;
        logic terminator;
        logic numeral;
        logic marker;
        logic pro_first;
        logic pro_second;
        logic pref_first;
        logic chapter;
    } unit_class_t;

    typedef struct packed {
        unit_class_t cls;
        logic        last;
    } queue_entry_t;

    function automatic logic is_numeral(input logic [UNIT_BITS-1:0] u);
        logic hit;
        case (u)
            16'h0020, 16'h0009, 16'h3000,
            16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034,
            16'h0035, 16'h0036, 16'h0037, 16'h0038, 16'h0039,
            16'h96F6, 16'h4E00, 16'h4E8C, 16'h4E09, 16'h56DB,
            16'h4E94, 16'h516D, 16'h4E03, 16'h516B, 16'h4E5D,
            16'h5341, 16'h767E, 16'h5343, 16'h4E07, 16'h4EBF,
            16'h58F9, 16'h8D30, 16'h53C1, 16'h8086, 16'h4F0D,
            16'h9646, 16'h67D2, 16'h634C, 16'h7396,
            16'h62FE, 16'h4F70, 16'h4EDF, 16'h842C, 16'h5104, 16'h4E24: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic unit_class_t classify(input logic [UNIT_BITS-1:0] u);
        unit_class_t c;
        c.newline    = (u == UNIT_NEWLINE);
        c.zero       = (u == UNIT_ZERO);
        c.separator  = (u == UNIT_SPACE) || (u == UNIT_TAB) || (u == UNIT_IDEO_SPACE) ||
                       (u == UNIT_NBSP) || (u == UNIT_WIDE_COLON) || (u == UNIT_COLON);
        c.terminator = (u == UNIT_VOLUME) || (u == UNIT_CHAPTER) ||
                       (u == UNIT_PART) || (u == UNIT_SECTION);
        c.numeral    = is_numeral(u);
        c.marker     = (u == UNIT_MARKER);
        c.pro_first  = (u == UNIT_PRO_FIRST);
        c.pro_second = (u == UNIT_PRO_SECOND);
        c.pref_first = (u == UNIT_PREF_FIRST);
        c.chapter    = (u == UNIT_CHAPTER);
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/chd_ifs.sv =====
// Valid/ready channel interfaces for text input and heading output.
`default_nettype none

interface chd_text_if import chd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [UNIT_BITS-1:0] code_unit;
    logic                 end_of_text;

    modport source (output valid, output code_unit, output end_of_text, input ready);
    modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

interface chd_heading_if import chd_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [OUT_OFFSET_BITS-1:0] heading_offset;
    logic [1:0]                 heading_kind;

    modport source (output valid, output heading_offset, output heading_kind, input ready);
    modport sink   (input valid, input heading_offset, input heading_kind, output ready);
endinterface

`default_nettype wire

// ===== design/chd_front.sv =====
// Front end: accepts code units and classifies them for the queue.
`default_nettype none

module chd_front import chd_pkg::*;
(
    chd_text_if.sink     text_in,
    input  wire logic    queue_ready,
    output queue_entry_t push_entry,
    output logic         push
);

    assign text_in.ready    = queue_ready;
    assign push             = text_in.valid && queue_ready;
    assign push_entry.cls   = classify(text_in.code_unit);
    assign push_entry.last  = text_in.end_of_text;

endmodule

`default_nettype wire

// ===== design/chd_queue.sv =====
// Short FIFO of classified items between front and back end.
`default_nettype none

module chd_queue import chd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire queue_entry_t  push_entry,
    output logic               push_ready,
    input  wire logic          pop,
    output queue_entry_t       pop_entry,
    output logic               pop_valid
);

    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    queue_entry_t         slot_reg [DEPTH];
    logic [IDX_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + IDX_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + IDX_BITS'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_BITS'(1);
            2'b01:   count_next = count_reg - CNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== design/chd_back.sv =====
// Back end: line scanner state, heading decisions and the output register.
`default_nettype none

`include "assert_macros.svh"

module chd_back import chd_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire queue_entry_t  entry,
    input  wire logic          entry_valid,
    output logic               entry_pop,
    chd_heading_if.source      heading_out
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] OFF_TWO = OFFSET_BITS'(2);

    logic [OFFSET_BITS-1:0] tp_reg, tp_next;
    logic [OFFSET_BITS-1:0] mpos_reg, mpos_next;
    logic                   mseen_reg, mseen_next;
    logic                   allv_reg, allv_next;
    logic                   nonempty_reg, nonempty_next;
    logic                   decided_reg, decided_next;
    unit_class_t            prev_reg, prev_next;
    unit_class_t            ubp_reg, ubp_next;
    logic [1:0]             lb_reg, lb_next;

    logic                       out_valid_reg;
    logic [OUT_OFFSET_BITS-1:0] out_off_reg;
    heading_kind_t              out_kind_reg;

    unit_class_t            c;
    logic                   tp_is_max, tp_is_zero, tp_is_one, tp_near_max;
    logic [OFFSET_BITS-1:0] back1, back2, back2_after, tp_inc;

    logic                   term_ok, word_ok;
    logic                   word_hit1, term_hit1, emit1, decided1;

    logic [OFFSET_BITS-1:0] mid_mpos;
    logic                   mid_mseen, mid_allv, mid_nonempty, mid_dec;
    unit_class_t            mid_prev, mid_ubp;
    logic [1:0]             mid_lb;

    logic                   check2, word_hit2, term_hit2;
    logic                   emit;
    logic [OFFSET_BITS-1:0] off_sel;
    logic [OFFSET_BITS+OUT_OFFSET_BITS-1:0] off_wide;
    heading_kind_t          kind_sel;

    assign c = entry.cls;

    // Offsets one and two units back, saturating like the position counter.
    assign tp_is_max   = (tp_reg == OFF_MAX);
    assign tp_is_zero  = (tp_reg == '0);
    assign tp_is_one   = (tp_reg == OFF_ONE);
    assign tp_near_max = tp_is_max || (tp_reg == OFF_MAX - OFF_ONE);
    assign back1       = tp_is_max ? OFF_MAX : (tp_is_zero ? '0 : tp_reg - OFF_ONE);
    assign back2       = tp_is_max ? OFF_MAX :
                         ((tp_is_zero || tp_is_one) ? '0 : tp_reg - OFF_TWO);
    assign tp_inc      = tp_is_max ? tp_reg : tp_reg + OFF_ONE;
    // Two back from the advanced position.
    assign back2_after = tp_near_max ? OFF_MAX : back1;

    always_comb
    begin
        term_ok = c.newline || c.separator || c.zero;
        word_ok = c.newline || c.separator;

        word_hit1 = !decided_reg && lb_reg[1] && word_ok && !mseen_reg &&
                    ((ubp_reg.pro_first && prev_reg.pro_second) ||
                     (ubp_reg.pref_first && prev_reg.chapter));
        term_hit1 = !decided_reg && !word_hit1 && (lb_reg != 2'b00) && term_ok &&
                    mseen_reg && prev_reg.terminator;
        emit1     = word_hit1 || (term_hit1 && nonempty_reg && allv_reg);
        decided1  = decided_reg || word_hit1 || term_hit1;

        mid_mpos     = mpos_reg;
        mid_mseen    = mseen_reg;
        mid_allv     = allv_reg;
        mid_nonempty = nonempty_reg;
        mid_dec      = decided1;
        mid_prev     = prev_reg;
        mid_ubp      = ubp_reg;
        mid_lb       = lb_reg;

        if (c.newline)
        begin
            mid_mpos     = '0;
            mid_mseen    = 1'b0;
            mid_allv     = 1'b1;
            mid_nonempty = 1'b0;
            mid_dec      = 1'b0;
            mid_prev     = '0;
            mid_ubp      = '0;
            mid_lb       = 2'b00;
        end
        else if (!decided1)
        begin
            if (lb_reg != 2'b00)
            begin
                if (prev_reg.marker)
                begin
                    // Restart the number after the latest marker.
                    mid_mseen    = 1'b1;
                    mid_mpos     = back1;
                    mid_allv     = 1'b1;
                    mid_nonempty = 1'b0;
                end
                else if (mseen_reg)
                begin
                    mid_nonempty = 1'b1;
                    if (!prev_reg.numeral)
                    begin
                        mid_allv = 1'b0;
                    end
                end
            end
            mid_ubp  = prev_reg;
            mid_prev = c;
            mid_lb   = lb_reg[1] ? 2'd2 : lb_reg + 2'd1;
        end

        // A final unit that is not a newline closes the line once more.
        check2    = entry.last && !c.newline && !emit1;
        word_hit2 = check2 && !mid_dec && mid_lb[1] && !mid_mseen &&
                    ((mid_ubp.pro_first && mid_prev.pro_second) ||
                     (mid_ubp.pref_first && mid_prev.chapter));
        term_hit2 = check2 && !mid_dec && !word_hit2 && (mid_lb != 2'b00) && mid_mseen &&
                    mid_prev.terminator && mid_nonempty && mid_allv;

        emit = emit1 || word_hit2 || term_hit2;

        if (word_hit1)
        begin
            off_sel  = back2;
            kind_sel = ubp_reg.pro_first ? KIND_PROLOGUE : KIND_PREFACE;
        end
        else if (emit1)
        begin
            off_sel  = mpos_reg;
            kind_sel = KIND_NUMBERED;
        end
        else if (word_hit2)
        begin
            off_sel  = back2_after;
            kind_sel = mid_ubp.pro_first ? KIND_PROLOGUE : KIND_PREFACE;
        end
        else
        begin
            off_sel  = mid_mpos;
            kind_sel = KIND_NUMBERED;
        end
        off_wide = {{OUT_OFFSET_BITS{1'b0}}, off_sel};

        if (entry.last)
        begin
            tp_next       = '0;
            mpos_next     = '0;
            mseen_next    = 1'b0;
            allv_next     = 1'b1;
            nonempty_next = 1'b0;
            decided_next  = 1'b0;
            prev_next     = '0;
            ubp_next      = '0;
            lb_next       = 2'b00;
        end
        else
        begin
            tp_next       = tp_inc;
            mpos_next     = mid_mpos;
            mseen_next    = mid_mseen;
            allv_next     = mid_allv;
            nonempty_next = mid_nonempty;
            decided_next  = mid_dec;
            prev_next     = mid_prev;
            ubp_next      = mid_ubp;
            lb_next       = mid_lb;
        end
    end

    // Advance whenever the output slot is free or being emptied.
    assign entry_pop = entry_valid && (!out_valid_reg || heading_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg        <= '0;
            mpos_reg      <= '0;
            mseen_reg     <= 1'b0;
            allv_reg      <= 1'b1;
            nonempty_reg  <= 1'b0;
            decided_reg   <= 1'b0;
            prev_reg      <= '0;
            ubp_reg       <= '0;
            lb_reg        <= 2'b00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (entry_pop)
            begin
                tp_reg       <= tp_next;
                mpos_reg     <= mpos_next;
                mseen_reg    <= mseen_next;
                allv_reg     <= allv_next;
                nonempty_reg <= nonempty_next;
                decided_reg  <= decided_next;
                prev_reg     <= prev_next;
                ubp_reg      <= ubp_next;
                lb_reg       <= lb_next;
            end
            if (entry_pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (heading_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_pop && emit)
        begin
            out_off_reg  <= off_wide[OUT_OFFSET_BITS-1:0];
            out_kind_reg <= kind_sel;
        end
    end

    assign heading_out.valid          = out_valid_reg;
    assign heading_out.heading_offset = out_off_reg;
    assign heading_out.heading_kind   = out_kind_reg;

    `CHD_ASSERT(a_lookback_range, clk, rst_n, lb_reg != 2'd3, "lookback count out of range")
    `CHD_ASSERT(a_decided_needs_lookback, clk, rst_n, !decided_reg || (lb_reg != 2'b00),
                "line decided with empty lookback")
    `CHD_ASSERT(a_marker_behind, clk, rst_n, mpos_reg <= tp_reg,
                "marker ahead of text position")
    `CHD_ASSERT_NEXT(a_text_end_rewinds, clk, rst_n, entry_pop && entry.last,
                     (tp_reg == '0) && !decided_reg && (lb_reg == 2'b00),
                     "state not rewound after end of text")

endmodule

`default_nettype wire

// ===== design/chapter_heading_detector_core.sv =====
// Top level of the chapter heading detector: front end, queue and back end.
//
//  channel      dir  handshake      payload
//  text_in      in   valid/ready    code_unit[15:0], end_of_text
//  heading_out  out  valid/ready    heading_offset[31:0], heading_kind[1:0]
//
// One code unit is taken per cycle while the queue has room.
// A result is written to the output register once the item that completes it has
// passed through the queue; a heading is decided on the unit after its last unit,
// or on that unit itself when it ends the text.
// Reset is asynchronous and returns the text position to offset 0.
// A stalled output holds the back end; the QUEUE_DEPTH-entry queue keeps taking
// items until it is full.
`default_nettype none

module chapter_heading_detector_core import chd_pkg::*;
#(
    parameter int OFFSET_BITS = 32,
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    chd_text_if.sink       text_in,
    chd_heading_if.source  heading_out
);

    queue_entry_t push_entry;
    queue_entry_t pop_entry;
    logic         push;
    logic         push_ready;
    logic         pop;
    logic         pop_valid;

    chd_front u_front (
        .text_in     (text_in),
        .queue_ready (push_ready),
        .push_entry  (push_entry),
        .push        (push)
    );

    chd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid)
    );

    chd_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (pop_entry),
        .entry_valid (pop_valid),
        .entry_pop   (pop),
        .heading_out (heading_out)
    );

endmodule

`default_nettype wire
